@@ hw/rtl/mfmd_pkg.sv @@
// Shared types and constants for the motor feedback multi-turn decoder.
package mfmd_pkg;

   localparam int TURN_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 19;

   localparam logic [CSR_INDEX_W-1:0] CSR_TORQUE_GAIN    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VELOCITY_GAIN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRAP_THRESHOLD = 2'd2;

   localparam logic [15:0] TORQUE_GAIN_RESET    = 16'd43254;
   localparam logic [18:0] VELOCITY_GAIN_RESET  = 19'd292821;
   localparam logic [15:0] WRAP_THRESHOLD_RESET = 16'd39321;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Turn count as seen by the outputs: only the low 17 bits of the
   // sign-extended count reach total_counts, and only the low 16 reach turn_number.
   localparam int TURN_OUT_W = 17;
   localparam int TOTAL_W    = 33;

   typedef struct packed {
      logic [7:0]            temperature_raw;
      logic signed [15:0]    current_raw;
      logic signed [15:0]    speed_raw;
      logic [15:0]           encoder_raw;
      logic [TURN_OUT_W-1:0] turn_low;
      logic [15:0]           initial_count;
   } mfmd_entry_type;

endpackage

@@ hw/rtl/mfmd_front.sv @@
// Front end: accepts frames and tracks first frame, previous count and turns.
module mfmd_front
   import mfmd_pkg::*;
#(
   parameter int TURN_BITS = TURN_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_temperature_raw,
   input  logic signed [15:0]    req_current_raw,
   input  logic signed [15:0]    req_speed_raw,
   input  logic [15:0]           req_encoder_raw,
   input  logic [15:0]           wrap_threshold,
   output logic                  push_valid,
   input  logic                  push_ready,
   output mfmd_entry_type        push_data
);

   logic                 seen_first_ff, seen_first_in;
   logic [15:0]          initial_ff, initial_in;
   logic [15:0]          previous_ff, previous_in;
   logic [TURN_BITS-1:0] turn_ff, turn_in;

   logic [TURN_BITS-1:0] turn_base;
   logic [15:0]          previous_eff;
   logic signed [16:0]   delta;
   logic signed [16:0]   pos_thr;
   logic signed [16:0]   neg_thr;
   logic                 accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      // The first frame acts as its own previous count, so it never wraps.
      turn_base    = seen_first_ff ? turn_ff : '0;
      previous_eff = seen_first_ff ? previous_ff : req_encoder_raw;
      initial_in   = seen_first_ff ? initial_ff : req_encoder_raw;
      delta   = $signed({1'b0, req_encoder_raw}) - $signed({1'b0, previous_eff});
      pos_thr = $signed({1'b0, wrap_threshold});
      neg_thr = -pos_thr;
      if (delta < neg_thr) begin
         turn_in = turn_base + TURN_BITS'(1);
      end else if (delta > pos_thr) begin
         turn_in = turn_base - TURN_BITS'(1);
      end else begin
         turn_in = turn_base;
      end
      seen_first_in = 1'b1;
      previous_in   = req_encoder_raw;
   end

   always_comb begin
      push_data.temperature_raw = req_temperature_raw;
      push_data.current_raw     = req_current_raw;
      push_data.speed_raw       = req_speed_raw;
      push_data.encoder_raw     = req_encoder_raw;
      push_data.turn_low        = TURN_OUT_W'($signed(turn_in));
      push_data.initial_count   = initial_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_first_ff <= 1'b0;
         initial_ff    <= '0;
         previous_ff   <= '0;
         turn_ff       <= '0;
      end else if (accept) begin
         seen_first_ff <= seen_first_in;
         initial_ff    <= initial_in;
         previous_ff   <= previous_in;
         turn_ff       <= turn_in;
      end
   end

endmodule

@@ hw/rtl/mfmd_queue.sv @@
// Short FIFO between the front end and the arithmetic back end.
module mfmd_queue
   import mfmd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  mfmd_entry_type in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output mfmd_entry_type out_data
);

   mfmd_entry_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign in_ready  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ hw/rtl/mfmd_back.sv @@
// Back end: gain multiplies, multi-turn total and the result register.
module mfmd_back
   import mfmd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  mfmd_entry_type         pop_data,
   input  logic [15:0]            torque_gain,
   input  logic [18:0]            velocity_gain,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [7:0]      rsp_temperature_c,
   output logic signed [23:0]     rsp_torque_q16,
   output logic signed [26:0]     rsp_velocity_q16,
   output logic [15:0]            rsp_position_count,
   output logic signed [15:0]     rsp_turn_number,
   output logic signed [32:0]     rsp_total_counts
);

   logic                      valid_ff, valid_in;
   logic signed [7:0]         temperature_ff;
   logic signed [23:0]        torque_ff;
   logic signed [26:0]        velocity_ff;
   logic [15:0]               position_ff;
   logic signed [15:0]        turn_number_ff;
   logic signed [TOTAL_W-1:0] total_ff;

   logic signed [32:0]        torque_prod;
   logic signed [35:0]        velocity_prod;
   logic [TOTAL_W-1:0]        total_in;
   logic                      load;

   assign pop_ready = !valid_ff || rsp_ready;
   assign load      = pop_valid && pop_ready;

   always_comb begin
      // An arithmetic shift by eight is the floor division by 256.
      torque_prod   = pop_data.current_raw * $signed({1'b0, torque_gain});
      velocity_prod = pop_data.speed_raw * $signed({1'b0, velocity_gain});
      total_in      = {pop_data.turn_low, 16'b0}
                    + TOTAL_W'(pop_data.encoder_raw)
                    - TOTAL_W'(pop_data.initial_count);
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         temperature_ff <= $signed(pop_data.temperature_raw);
         torque_ff      <= torque_prod[31:8];
         velocity_ff    <= velocity_prod[34:8];
         position_ff    <= pop_data.encoder_raw;
         turn_number_ff <= $signed(pop_data.turn_low[15:0]);
         total_ff       <= $signed(total_in);
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_temperature_c  = temperature_ff;
   assign rsp_torque_q16     = torque_ff;
   assign rsp_velocity_q16   = velocity_ff;
   assign rsp_position_count = position_ff;
   assign rsp_turn_number    = turn_number_ff;
   assign rsp_total_counts   = total_ff;

endmodule

@@ hw/rtl/motor_feedback_multiturn_decode_top.sv @@
// Top level of the motor feedback multi-turn decoder.
//
// The req_ channel takes one decoded feedback frame per beat: temperature
// byte, current word, speed word and single-turn encoder count. The rsp_
// channel returns one beat per frame with the signed temperature, torque and
// velocity in Q16, the encoder count, the turn number and the multi-turn
// total in counts. The csr_ port writes the torque gain, velocity gain and
// wrap threshold; write it only while no frame is in flight.
// A frame accepted at one clock edge goes into the queue, then into the result
// register, and is presented on rsp_. One frame per cycle is sustained while
// rsp_ready stays high: the front end updates the turn state in the accepting
// cycle, and the back end feeds both gain products into the result register.
// When the receiver stalls, the two-entry queue and the result register hold
// up to three frames before req_ready drops.
// Reset restores the register defaults, empties the queue and result
// register, and makes the next frame the first one, which captures the
// initial count and clears the turn count.
module motor_feedback_multiturn_decode_top
   import mfmd_pkg::*;
#(
   parameter int TURN_BITS = TURN_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_temperature_raw,
   input  logic signed [15:0]     req_current_raw,
   input  logic signed [15:0]     req_speed_raw,
   input  logic [15:0]            req_encoder_raw,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [7:0]      rsp_temperature_c,
   output logic signed [23:0]     rsp_torque_q16,
   output logic signed [26:0]     rsp_velocity_q16,
   output logic [15:0]            rsp_position_count,
   output logic signed [15:0]     rsp_turn_number,
   output logic signed [32:0]     rsp_total_counts,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [15:0]    torque_gain_ff;
   logic [18:0]    velocity_gain_ff;
   logic [15:0]    wrap_threshold_ff;

   logic           push_valid;
   logic           push_ready;
   mfmd_entry_type push_data;
   logic           pop_valid;
   logic           pop_ready;
   mfmd_entry_type pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         torque_gain_ff    <= TORQUE_GAIN_RESET;
         velocity_gain_ff  <= VELOCITY_GAIN_RESET;
         wrap_threshold_ff <= WRAP_THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TORQUE_GAIN:    torque_gain_ff    <= csr_write_data[15:0];
            CSR_VELOCITY_GAIN:  velocity_gain_ff  <= csr_write_data[18:0];
            CSR_WRAP_THRESHOLD: wrap_threshold_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   mfmd_front #(
      .TURN_BITS (TURN_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_temperature_raw (req_temperature_raw),
      .req_current_raw     (req_current_raw),
      .req_speed_raw       (req_speed_raw),
      .req_encoder_raw     (req_encoder_raw),
      .wrap_threshold      (wrap_threshold_ff),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_data           (push_data)
   );

   mfmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   mfmd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_data           (pop_data),
      .torque_gain        (torque_gain_ff),
      .velocity_gain      (velocity_gain_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_temperature_c  (rsp_temperature_c),
      .rsp_torque_q16     (rsp_torque_q16),
      .rsp_velocity_q16   (rsp_velocity_q16),
      .rsp_position_count (rsp_position_count),
      .rsp_turn_number    (rsp_turn_number),
      .rsp_total_counts   (rsp_total_counts)
   );

endmodule

@@ tb/feedback_decode_checker.sv @@
// Checker that predicts and compares every decoded feedback beat.
`timescale 1ns / 100ps
module feedback_decode_checker
   import mfmd_pkg::*;
#(
   parameter int TURN_BITS = TURN_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_temperature_raw,
   input  logic signed [15:0]     req_current_raw,
   input  logic signed [15:0]     req_speed_raw,
   input  logic [15:0]            req_encoder_raw,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic signed [7:0]      rsp_temperature_c,
   input  logic signed [23:0]     rsp_torque_q16,
   input  logic signed [26:0]     rsp_velocity_q16,
   input  logic [15:0]            rsp_position_count,
   input  logic signed [15:0]     rsp_turn_number,
   input  logic signed [32:0]     rsp_total_counts,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     failures,
   output int                     frames_pending,
   output int                     frames_checked
);

   typedef struct {
      logic signed [7:0]  temperature_c;
      logic signed [23:0] torque_q16;
      logic signed [26:0] velocity_q16;
      logic [15:0]        position_count;
      logic signed [15:0] turn_number;
      logic signed [32:0] total_counts;
   } decoded_frame_type;

   logic [15:0]                 torque_gain;
   logic [18:0]                 velocity_gain;
   logic [15:0]                 wrap_threshold;
   logic                        seen_first;
   logic [15:0]                 initial_count;
   logic [15:0]                 previous_count;
   logic signed [TURN_BITS-1:0] turn_count;
   decoded_frame_type           decodes_due[$];
   decoded_frame_type           oldest;

   initial begin
      failures       = 0;
      frames_pending = 0;
      frames_checked = 0;
   end

   // Scales the frame and advances the turn unwrap state by one frame.
   function automatic decoded_frame_type decode_feedback_frame(
      input logic [7:0]         temp_raw,
      input logic signed [15:0] current,
      input logic signed [15:0] speed,
      input logic [15:0]        encoder
   );
      decoded_frame_type frame;
      longint            torque_full;
      longint            velocity_full;
      longint            jump;
      longint            turns;
      longint            total;
      // An arithmetic shift of the signed product rounds toward minus infinity.
      torque_full   = (longint'(current) * longint'(torque_gain)) >>> 8;
      velocity_full = (longint'(speed) * longint'(velocity_gain)) >>> 8;
      if (!seen_first) begin
         initial_count  = encoder;
         previous_count = encoder;
         turn_count     = '0;
         seen_first     = 1'b1;
      end
      jump = longint'(encoder) - longint'(previous_count);
      if (jump < -longint'(wrap_threshold)) begin
         turn_count = turn_count + 1'b1;
      end else if (jump > longint'(wrap_threshold)) begin
         turn_count = turn_count - 1'b1;
      end
      previous_count = encoder;
      turns = longint'(turn_count);
      total = turns * 65536 + longint'(encoder) - longint'(initial_count);
      frame.temperature_c  = temp_raw;
      frame.torque_q16     = 24'(torque_full);
      frame.velocity_q16   = 27'(velocity_full);
      frame.position_count = encoder;
      frame.turn_number    = 16'(turns);
      frame.total_counts   = 33'(total);
      return frame;
   endfunction

   task automatic compare_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         torque_gain    = TORQUE_GAIN_RESET;
         velocity_gain  = VELOCITY_GAIN_RESET;
         wrap_threshold = WRAP_THRESHOLD_RESET;
         seen_first     = 1'b0;
         initial_count  = '0;
         previous_count = '0;
         turn_count     = '0;
         decodes_due.delete();
      end else begin
         // A response beat always belongs to a frame accepted at an earlier edge.
         if (rsp_valid && rsp_ready) begin
            if (decodes_due.size() == 0) begin
               $error("response beat arrived with no frame outstanding");
               failures++;
            end else begin
               oldest = decodes_due.pop_front();
               compare_field("temperature_c", oldest.temperature_c, rsp_temperature_c);
               compare_field("torque_q16", oldest.torque_q16, rsp_torque_q16);
               compare_field("velocity_q16", oldest.velocity_q16, rsp_velocity_q16);
               compare_field("position_count", oldest.position_count, rsp_position_count);
               compare_field("turn_number", oldest.turn_number, rsp_turn_number);
               compare_field("total_counts", oldest.total_counts, rsp_total_counts);
               frames_checked++;
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TORQUE_GAIN:    torque_gain    = csr_write_data[15:0];
               CSR_VELOCITY_GAIN:  velocity_gain  = csr_write_data[18:0];
               CSR_WRAP_THRESHOLD: wrap_threshold = csr_write_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            decodes_due.push_back(decode_feedback_frame(req_temperature_raw, req_current_raw,
                                                        req_speed_raw, req_encoder_raw));
         end
      end
      frames_pending = decodes_due.size();
   end

endmodule

@@ tb/tb.sv @@
// Testbench top: drives feedback frames and register writes into the decoder.
`timescale 1ns / 100ps
module tb;
   import mfmd_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int TURN_SWEEP   = 60;
   localparam int RANDOM_BURST = 160;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_temperature_raw = '0;
   logic signed [15:0]     req_current_raw  = '0;
   logic signed [15:0]     req_speed_raw    = '0;
   logic [15:0]            req_encoder_raw  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic signed [7:0]      rsp_temperature_c;
   logic signed [23:0]     rsp_torque_q16;
   logic signed [26:0]     rsp_velocity_q16;
   logic [15:0]            rsp_position_count;
   logic signed [15:0]     rsp_turn_number;
   logic signed [32:0]     rsp_total_counts;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   int failures;
   int frames_pending;
   int frames_checked;
   int frames_sent    = 0;
   int send_gap_pct   = 31;
   int rsp_stall_pct  = 31;
   int last_encoder   = 0;
   int jump_threshold = int'(WRAP_THRESHOLD_RESET);
   int stall_cycles   = 0;

   motor_feedback_multiturn_decode_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_temperature_raw (req_temperature_raw),
      .req_current_raw     (req_current_raw),
      .req_speed_raw       (req_speed_raw),
      .req_encoder_raw     (req_encoder_raw),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_temperature_c   (rsp_temperature_c),
      .rsp_torque_q16      (rsp_torque_q16),
      .rsp_velocity_q16    (rsp_velocity_q16),
      .rsp_position_count  (rsp_position_count),
      .rsp_turn_number     (rsp_turn_number),
      .rsp_total_counts    (rsp_total_counts),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   feedback_decode_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_temperature_raw (req_temperature_raw),
      .req_current_raw     (req_current_raw),
      .req_speed_raw       (req_speed_raw),
      .req_encoder_raw     (req_encoder_raw),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_temperature_c   (rsp_temperature_c),
      .rsp_torque_q16      (rsp_torque_q16),
      .rsp_velocity_q16    (rsp_velocity_q16),
      .rsp_position_count  (rsp_position_count),
      .rsp_turn_number     (rsp_turn_number),
      .rsp_total_counts    (rsp_total_counts),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .failures            (failures),
      .frames_pending      (frames_pending),
      .frames_checked      (frames_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= (int'($urandom_range(99)) >= rsp_stall_pct);
   end

   // Ends the run when no beat moves on either channel for too long.
   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Entered and left at a falling edge; valid stays high into the next frame.
   task automatic send_frame(input logic [7:0] temp_raw, input logic [15:0] current,
                             input logic [15:0] speed, input logic [15:0] encoder);
      while (int'($urandom_range(99)) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_temperature_raw = temp_raw;
      req_current_raw     = current;
      req_speed_raw       = speed;
      req_encoder_raw     = encoder;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      last_encoder = int'(encoder);
      frames_sent++;
   endtask

   // Random temperature, current and speed with a chosen encoder count.
   task automatic send_spin_frame(input logic [15:0] encoder);
      send_frame(8'($urandom_range(255)), 16'($urandom_range(65535)),
                 16'($urandom_range(65535)), encoder);
   endtask

   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (frames_pending != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input int data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = CSR_DATA_W'(data);
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (index == CSR_WRAP_THRESHOLD) begin
         jump_threshold = data;
      end
   endtask

   task automatic write_all_registers(input int torque, input int velocity, input int threshold);
      wait_for_drain();
      write_register(CSR_TORQUE_GAIN, torque);
      write_register(CSR_VELOCITY_GAIN, velocity);
      write_register(CSR_WRAP_THRESHOLD, threshold);
   endtask

   // Mostly a rotating shaft with random steps, plus jumps right at the
   // threshold and arbitrary counts.
   task automatic run_random_frames(input int count);
      int step;
      int span;
      int encoder;
      repeat (count) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
               step    = int'($urandom_range(40000)) - 20000;
               encoder = (last_encoder + step) & 16'hFFFF;
            end
            6, 7: begin
               span = jump_threshold + int'($urandom_range(2)) - 1;
               if ($urandom_range(1) == 1 && last_encoder + span <= 65535) begin
                  encoder = last_encoder + span;
               end else if (last_encoder - span >= 0) begin
                  encoder = last_encoder - span;
               end else if (last_encoder + span <= 65535) begin
                  encoder = last_encoder + span;
               end else begin
                  encoder = $urandom_range(65535);
               end
            end
            default: encoder = $urandom_range(65535);
         endcase
         send_spin_frame(16'(encoder));
      end
   endtask

   initial begin
      int turn;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Reset gains and threshold; the first frame captures the initial count.
      send_frame(8'd0, 16'h0000, 16'h0000, 16'd1000);
      send_frame(8'd127, 16'h7FFF, 16'h7FFF, 16'd40321);   // jump equal to threshold
      send_frame(8'd128, 16'h8000, 16'h8000, 16'd1000);    // same, downward
      send_frame(8'd255, 16'hFFFF, 16'hFFFF, 16'd40322);   // one past: turn back
      send_frame(8'd1, 16'h0001, 16'h0001, 16'd1000);      // one past: turn forward
      send_frame(8'd64, 16'h7FFF, 16'h8000, 16'd65535);
      send_frame(8'd200, 16'h8000, 16'h7FFF, 16'd0);
      send_frame(8'd33, 16'h1234, 16'hEDCB, 16'd0);
      send_frame(8'd90, 16'hFF00, 16'h00FF, 16'd65535);
      send_frame(8'd170, 16'h5555, 16'hAAAA, 16'd65535);

      // Zero gains and a threshold of 32768.
      write_all_registers(0, 0, 32768);
      send_frame(8'd85, 16'h7FFF, 16'h8000, 16'd32768);
      send_frame(8'd86, 16'h8000, 16'h7FFF, 16'd0);
      send_frame(8'd87, 16'h0001, 16'hFFFF, 16'd32767);
      send_frame(8'd88, 16'hFFFF, 16'h0001, 16'd65535);

      // Full-scale gains; with the top threshold no jump can count as a turn.
      write_all_registers(65535, 524287, 65535);
      send_frame(8'd127, 16'h7FFF, 16'h7FFF, 16'd0);
      send_frame(8'd128, 16'h8000, 16'h8000, 16'd65535);
      send_frame(8'd255, 16'h7FFF, 16'h8000, 16'd0);
      send_frame(8'd0, 16'h8000, 16'h7FFF, 16'd65535);

      // A write to the unused index must leave every register alone.
      wait_for_drain();
      write_register(CSR_UNMAPPED, $urandom_range(524287));
      send_frame(8'd19, 16'h8000, 16'h8000, 16'd1);
      send_frame(8'd20, 16'h7FFF, 16'h7FFF, 16'd65534);

      // Steady rotation with both sides at full rate: a run of forward turns,
      // then the same number back the other way.
      write_all_registers($urandom_range(65535), $urandom_range(524287), 32768);
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      for (turn = 0; turn < TURN_SWEEP; turn++) begin
         send_spin_frame(16'd0);
         send_spin_frame(16'd21845);
         send_spin_frame(16'd43690);
      end
      for (turn = 0; turn < TURN_SWEEP; turn++) begin
         send_spin_frame(16'd0);
         send_spin_frame(16'd43690);
         send_spin_frame(16'd21845);
      end
      wait_for_drain();
      send_gap_pct  = 31;
      rsp_stall_pct = 31;

      write_all_registers(int'(TORQUE_GAIN_RESET), int'(VELOCITY_GAIN_RESET),
                          int'(WRAP_THRESHOLD_RESET));
      run_random_frames(RANDOM_BURST);
      write_all_registers($urandom_range(65535), $urandom_range(524287),
                          $urandom_range(65535, 32768));
      run_random_frames(RANDOM_BURST);
      write_all_registers($urandom_range(65535), $urandom_range(524287), 32768);
      run_random_frames(RANDOM_BURST);
      write_all_registers(65535, 524287, 65535);
      run_random_frames(RANDOM_BURST);

      wait_for_drain();
      repeat (4) @(negedge clock);
      $display("Sent %0d frames, %0d responses checked: field extremes, threshold edges,",
               frames_sent, frames_checked);
      $display("full-rate rotation both ways, several register settings with random stalls.");
      if (failures == 0 && frames_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/mfmd_pkg.sv
hw/rtl/mfmd_front.sv
hw/rtl/mfmd_queue.sv
hw/rtl/mfmd_back.sv
hw/rtl/motor_feedback_multiturn_decode_top.sv
tb/feedback_decode_checker.sv
tb/tb.sv
